/* hdl/pctbl_pkg.sv */
// ----------------------------------------------------------------------------
// pctbl_pkg
// Shared types, constants and helpers of the per-client token bucket limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package pctbl_pkg;

  // table geometry
  localparam int TABLE_ENTRIES   = 1024;
  localparam int IDX_W           = $clog2(TABLE_ENTRIES);
  localparam int CNT_W           = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int TOKEN_FRAC_BITS = 16;
  localparam int BURST_W         = 16;
  localparam int TOKEN_W         = BURST_W + TOKEN_FRAC_BITS;
  localparam int TIME_W          = 40;
  localparam int INTV_W          = 24;
  localparam int DIVD_W          = TIME_W + TOKEN_FRAC_BITS;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;

  // timing constants in ms
  localparam logic [TIME_W-1:0] SWEEP_MS      = TIME_W'(60000);
  localparam logic [TIME_W-1:0] FORCED_GAP_MS = TIME_W'(1000);
  localparam logic [INTV_W-1:0] KOD_MIN_MS    = INTV_W'(1000);

  // address families
  localparam logic [1:0] FAM_UNKNOWN = 2'd0;
  localparam logic [1:0] FAM_IPV4    = 2'd1;
  localparam logic [1:0] FAM_IPV6    = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL  = 3'd0,
    CFG_BURST     = 3'd1,
    CFG_V4_PREFIX = 3'd2,
    CFG_V6_PREFIX = 3'd3,
    CFG_LEAK      = 3'd4,
    CFG_KOD_EN    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_ANSWER = 2'd0,
    VERDICT_LEAK   = 2'd1,
    VERDICT_KOD    = 2'd2,
    VERDICT_DROP   = 2'd3
  } verdict_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DECIDE,
    ST_DIV,
    ST_REFILL,
    ST_APPLY,
    ST_INSERT,
    ST_RESP
  } state_e;

  // one bucket entry as held in the table memory
  typedef struct packed {
    logic               valid;
    logic               is_v6;
    logic [63:0]        key_hi;
    logic [63:0]        key_lo;
    logic [TOKEN_W-1:0] tokens;
    logic [TIME_W-1:0]  last_seen;
    logic [TIME_W-1:0]  kod_time;
    logic               kod_sent;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // elapsed time, clamped at zero when time runs backwards
  function automatic logic [TIME_W-1:0] since(input logic [TIME_W-1:0] now,
                                              input logic [TIME_W-1:0] t);
    return (now >= t) ? (now - t) : '0;
  endfunction

  // n leading ones in a 64-bit word, n up to 64
  function automatic logic [63:0] lead_mask(input logic [6:0] n);
    logic [63:0] m;
    m = (n == 7'd0) ? 64'd0 : (~64'd0 << (7'd64 - n));
    return m;
  endfunction

endpackage

`default_nettype wire

/* hdl/pctbl_req_if.sv */
// ----------------------------------------------------------------------------
// pctbl_req_if
// Request channel: one client request per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pctbl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr_family;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic        exempt;
  logic [pctbl_pkg::TIME_W-1:0] now_ms;
  logic [15:0] random_draw;

  modport source (output valid, addr_family, addr_hi, addr_lo, exempt, now_ms,
                  random_draw, input ready);
  modport sink   (input valid, addr_family, addr_hi, addr_lo, exempt, now_ms,
                  random_draw, output ready);
endinterface

`default_nettype wire

/* hdl/pctbl_rsp_if.sv */
// ----------------------------------------------------------------------------
// pctbl_rsp_if
// Response channel: one verdict per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pctbl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [pctbl_pkg::CNT_W-1:0] tracked_count;

  modport source (output valid, verdict, tracked_count, input ready);
  modport sink   (input valid, verdict, tracked_count, output ready);
endinterface

`default_nettype wire

/* hdl/pctbl_ram.sv */
// ----------------------------------------------------------------------------
// pctbl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pctbl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/pctbl_div.sv */
// ----------------------------------------------------------------------------
// pctbl_div
// Restoring divider, one quotient bit per cycle, for the token refill.
// ----------------------------------------------------------------------------
`default_nettype none

module pctbl_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [pctbl_pkg::DIVD_W-1:0]    dividend_i,
  input  wire logic [pctbl_pkg::INTV_W-1:0]    divisor_i,
  output logic                                 done_o,
  output logic      [pctbl_pkg::TOKEN_W-1:0]   quot_o
);

  localparam int CW = $clog2(pctbl_pkg::DIVD_W + 1);

  logic                           busy_q;
  logic [CW-1:0]                  cnt_q;
  logic [pctbl_pkg::DIVD_W-1:0]   quot_q;
  logic [pctbl_pkg::INTV_W-1:0]   rem_q;
  logic [pctbl_pkg::INTV_W-1:0]   dvs_q;
  logic [pctbl_pkg::INTV_W:0]     rem_sh;
  logic [pctbl_pkg::INTV_W:0]     diff;
  logic                           ge;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, quot_q[pctbl_pkg::DIVD_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = (rem_sh >= {1'b0, dvs_q});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(pctbl_pkg::DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[pctbl_pkg::INTV_W-1:0] : rem_sh[pctbl_pkg::INTV_W-1:0];
      quot_q <= {quot_q[pctbl_pkg::DIVD_W-2:0], ge};
    end
  end

  assign quot_o = quot_q[pctbl_pkg::TOKEN_W-1:0];

endmodule

`default_nettype wire

/* hdl/per_client_token_bucket_limiter.sv */
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter
// Per-client token bucket policer with a table of buckets held in one RAM.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_i    in   valid/ready   addr_family addr_hi addr_lo exempt now_ms random_draw
//  rsp_o    out  valid/ready   verdict tracked_count
//  cfg      in   cfg_we_i      cfg_idx_i cfg_wdata_i
//
//  Untracked requests go from ST_IDLE straight to ST_RESP. Tracked ones scan
//  the whole table, one entry a cycle through the RAM read port, then insert a
//  new client or refill a known one through the divider; a full table may add
//  a forced sweep pass. After reset a clearing pass writes every entry before
//  the first request. A verdict stalled on rsp_o.ready holds the next one in
//  ST_RESP.
// ----------------------------------------------------------------------------
`default_nettype none

module per_client_token_bucket_limiter (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pctbl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [pctbl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  pctbl_req_if.sink                                req_i,
  pctbl_rsp_if.source                              rsp_o
);

  localparam int TW = pctbl_pkg::TIME_W;
  localparam int KW = pctbl_pkg::TOKEN_W;

  pctbl_pkg::state_e state_q, state_d;

  // configuration
  logic [pctbl_pkg::INTV_W-1:0]  interval_q;
  logic [pctbl_pkg::BURST_W-1:0] burst_q;
  logic [5:0]                    v4len_q;
  logic [7:0]                    v6len_q;
  logic [15:0]                   leak_q;
  logic                          kod_en_q;

  // request under work
  logic                          v6_q;
  logic [63:0]                   key_hi_q, key_lo_q;
  logic [TW-1:0]                 now_q;
  logic [15:0]                   draw_q;
  logic [TW-1:0]                 full_q, limit_q, el_q;
  logic                          sweep_en_q, match_en_q, forced_q;

  // scan
  logic [pctbl_pkg::IDX_W:0]     scan_idx_q;
  logic                          rd_pend_q;
  logic [pctbl_pkg::IDX_W-1:0]   rd_addr_q;
  logic                          hit_q, free_q;
  logic [pctbl_pkg::IDX_W-1:0]   hit_addr_q, free_addr_q;
  pctbl_pkg::entry_t             hit_ent_q;

  // table state
  logic [pctbl_pkg::CNT_W-1:0]   count_q;
  logic [TW-1:0]                 last_sweep_q;

  // results
  logic [KW-1:0]                 refill_q;
  pctbl_pkg::verdict_e           res_q;
  logic                          rsp_valid_q;
  logic [1:0]                    rsp_verdict_q;
  logic [pctbl_pkg::CNT_W-1:0]   rsp_count_q;

  // ram ports
  logic                          ram_we, ram_re;
  logic [pctbl_pkg::IDX_W-1:0]   ram_waddr;
  logic [pctbl_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  pctbl_pkg::entry_t             rd_ent, upd_ent, new_ent;

  // divider
  logic                          div_start, div_done;
  logic [KW-1:0]                 div_quot;

  // misc comb
  logic                          req_acc, untracked, v6_in, issue, scan_done;
  logic                          stale, live, match, slot_free, table_full;
  logic [7:0]                    p6;
  logic [5:0]                    p4;
  logic [6:0]                    hi_n, lo_n;
  logic [63:0]                   key_hi_in, key_lo_in;
  logic [TW-1:0]                 full_c, el_c, kgap;
  logic [KW-1:0]                 cap;
  logic [KW:0]                   sum;
  logic                          kod_ok, leak_ok, spend_ok;
  pctbl_pkg::verdict_e           apply_verdict;

  pctbl_ram #(
    .Width (pctbl_pkg::ENTRY_W),
    .Depth (pctbl_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_idx_q[pctbl_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  pctbl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({el_c, {pctbl_pkg::TOKEN_FRAC_BITS{1'b0}}}),
    .divisor_i  (interval_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // request decode and key forming
  always_comb begin
    req_acc   = req_i.valid && req_i.ready;
    v6_in     = (req_i.addr_family == pctbl_pkg::FAM_IPV6);
    untracked = (interval_q == '0) || req_i.exempt ||
                !((req_i.addr_family == pctbl_pkg::FAM_IPV4) || v6_in);
    p6        = (v6len_q > 8'd128) ? 8'd128 : v6len_q;
    hi_n      = (p6 > 8'd64) ? 7'd64 : p6[6:0];
    lo_n      = (p6 > 8'd64) ? 7'(p6 - 8'd64) : 7'd0;
    p4        = (v4len_q > 6'd32) ? 6'd32 : v4len_q;
    if (v6_in) begin
      key_hi_in = req_i.addr_hi & pctbl_pkg::lead_mask(hi_n);
      key_lo_in = req_i.addr_lo & pctbl_pkg::lead_mask(lo_n);
    end else begin
      key_hi_in = req_i.addr_hi & pctbl_pkg::lead_mask({1'b0, p4}) &
                  64'hFFFF_FFFF_0000_0000;
      key_lo_in = '0;
    end
  end

  // scan evaluation of the entry read last cycle
  always_comb begin
    rd_ent     = pctbl_pkg::entry_t'(ram_rdata);
    issue      = (state_q == pctbl_pkg::ST_SCAN) &&
                 (scan_idx_q < (pctbl_pkg::IDX_W+1)'(pctbl_pkg::TABLE_ENTRIES));
    scan_done  = (state_q == pctbl_pkg::ST_SCAN) && !issue && !rd_pend_q;
    stale      = rd_pend_q && sweep_en_q && rd_ent.valid &&
                 (pctbl_pkg::since(now_q, rd_ent.last_seen) > limit_q);
    live       = rd_ent.valid && !stale;
    match      = rd_pend_q && match_en_q && live && (rd_ent.is_v6 == v6_q) &&
                 (rd_ent.key_hi == key_hi_q) && (rd_ent.key_lo == key_lo_q);
    slot_free  = rd_pend_q && !live;
    table_full = (count_q >= pctbl_pkg::CNT_W'(pctbl_pkg::TABLE_ENTRIES));
    full_c     = TW'(burst_q) * TW'(interval_q);
    el_c       = pctbl_pkg::since(now_q, hit_ent_q.last_seen);
  end

  // bucket update arithmetic
  always_comb begin
    cap      = {burst_q, {pctbl_pkg::TOKEN_FRAC_BITS{1'b0}}};
    sum      = {1'b0, hit_ent_q.tokens} + {1'b0, div_quot};
    kgap     = TW'((interval_q > pctbl_pkg::KOD_MIN_MS) ? interval_q
                                                       : pctbl_pkg::KOD_MIN_MS);
    spend_ok = (refill_q >= KW'(1) << pctbl_pkg::TOKEN_FRAC_BITS);
    leak_ok  = (leak_q != '0) && (draw_q < leak_q);
    kod_ok   = kod_en_q && (!hit_ent_q.kod_sent ||
               (pctbl_pkg::since(now_q, hit_ent_q.kod_time) >= kgap));
    upd_ent           = hit_ent_q;
    upd_ent.last_seen = now_q;
    upd_ent.tokens    = refill_q;
    if (spend_ok) begin
      apply_verdict  = pctbl_pkg::VERDICT_ANSWER;
      upd_ent.tokens = refill_q - (KW'(1) << pctbl_pkg::TOKEN_FRAC_BITS);
    end else if (leak_ok) begin
      apply_verdict  = pctbl_pkg::VERDICT_LEAK;
    end else if (kod_ok) begin
      apply_verdict    = pctbl_pkg::VERDICT_KOD;
      upd_ent.kod_time = now_q;
      upd_ent.kod_sent = 1'b1;
    end else begin
      apply_verdict  = pctbl_pkg::VERDICT_DROP;
    end
    new_ent.valid     = 1'b1;
    new_ent.is_v6     = v6_q;
    new_ent.key_hi    = key_hi_q;
    new_ent.key_lo    = key_lo_q;
    new_ent.tokens    = (burst_q != '0) ?
                        {burst_q - 16'd1, {pctbl_pkg::TOKEN_FRAC_BITS{1'b0}}} : '0;
    new_ent.last_seen = now_q;
    new_ent.kod_time  = '0;
    new_ent.kod_sent  = 1'b0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pctbl_pkg::ST_CLEAR: begin
        if (scan_idx_q == (pctbl_pkg::IDX_W+1)'(pctbl_pkg::TABLE_ENTRIES - 1)) begin
          state_d = pctbl_pkg::ST_IDLE;
        end
      end
      pctbl_pkg::ST_IDLE: begin
        if (req_acc) begin
          state_d = untracked ? pctbl_pkg::ST_RESP : pctbl_pkg::ST_START;
        end
      end
      pctbl_pkg::ST_START:  state_d = pctbl_pkg::ST_SCAN;
      pctbl_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = pctbl_pkg::ST_DECIDE;
        end
      end
      pctbl_pkg::ST_DECIDE: begin
        if (hit_q) begin
          state_d = pctbl_pkg::ST_DIV;
        end else if (!table_full) begin
          state_d = pctbl_pkg::ST_INSERT;
        end else if (forced_q ||
                     (pctbl_pkg::since(now_q, last_sweep_q) < pctbl_pkg::FORCED_GAP_MS)) begin
          state_d = pctbl_pkg::ST_RESP;
        end else begin
          state_d = pctbl_pkg::ST_SCAN;
        end
      end
      pctbl_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = pctbl_pkg::ST_REFILL;
        end
      end
      pctbl_pkg::ST_REFILL: state_d = pctbl_pkg::ST_APPLY;
      pctbl_pkg::ST_APPLY:  state_d = pctbl_pkg::ST_RESP;
      pctbl_pkg::ST_INSERT: state_d = pctbl_pkg::ST_RESP;
      pctbl_pkg::ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = pctbl_pkg::ST_IDLE;
        end
      end
      default: state_d = pctbl_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine: ram and divider control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr_q;
    ram_wdata = '0;
    ram_re    = issue;
    div_start = (state_q == pctbl_pkg::ST_DECIDE) && hit_q;
    unique case (state_q)
      pctbl_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_idx_q[pctbl_pkg::IDX_W-1:0];
      end
      pctbl_pkg::ST_SCAN: begin
        ram_we    = stale;
        ram_wdata = {1'b0, ram_rdata[pctbl_pkg::ENTRY_W-2:0]};
      end
      pctbl_pkg::ST_APPLY: begin
        ram_we    = 1'b1;
        ram_waddr = hit_addr_q;
        ram_wdata = upd_ent;
      end
      pctbl_pkg::ST_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = free_addr_q;
        ram_wdata = new_ent;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign req_i.ready = (state_q == pctbl_pkg::ST_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      burst_q    <= 16'd8;
      v4len_q    <= 6'd32;
      v6len_q    <= 8'd64;
      leak_q     <= '0;
      kod_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pctbl_pkg::CFG_INTERVAL:  interval_q <= cfg_wdata_i;
        pctbl_pkg::CFG_BURST:     burst_q    <= cfg_wdata_i[15:0];
        pctbl_pkg::CFG_V4_PREFIX: v4len_q    <= cfg_wdata_i[5:0];
        pctbl_pkg::CFG_V6_PREFIX: v6len_q    <= cfg_wdata_i[7:0];
        pctbl_pkg::CFG_LEAK:      leak_q     <= cfg_wdata_i[15:0];
        pctbl_pkg::CFG_KOD_EN:    kod_en_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pctbl_pkg::ST_CLEAR;
      scan_idx_q   <= '0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      count_q      <= '0;
      last_sweep_q <= '0;
      rsp_valid_q  <= 1'b0;
      sweep_en_q   <= 1'b0;
      match_en_q   <= 1'b0;
      forced_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      // response register: load a verdict or retire the one taken
      if ((state_q == pctbl_pkg::ST_RESP) && (!rsp_valid_q || rsp_o.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        pctbl_pkg::ST_CLEAR: begin
          scan_idx_q <= scan_idx_q + (pctbl_pkg::IDX_W+1)'(1);
        end
        pctbl_pkg::ST_START: begin
          scan_idx_q <= '0;
          rd_pend_q  <= 1'b0;
          hit_q      <= 1'b0;
          free_q     <= 1'b0;
          forced_q   <= 1'b0;
          match_en_q <= 1'b1;
          sweep_en_q <= (pctbl_pkg::since(now_q, last_sweep_q) > pctbl_pkg::SWEEP_MS);
          if (pctbl_pkg::since(now_q, last_sweep_q) > pctbl_pkg::SWEEP_MS) begin
            last_sweep_q <= now_q;
          end
        end
        pctbl_pkg::ST_SCAN: begin
          rd_pend_q <= issue;
          if (issue) begin
            scan_idx_q <= scan_idx_q + (pctbl_pkg::IDX_W+1)'(1);
          end
          if (stale) begin
            count_q <= count_q - pctbl_pkg::CNT_W'(1);
          end
          if (match) begin
            hit_q <= 1'b1;
          end
          if (slot_free && !free_q) begin
            free_q <= 1'b1;
          end
        end
        pctbl_pkg::ST_DECIDE: begin
          if (state_d == pctbl_pkg::ST_SCAN) begin
            // forced sweep pass
            last_sweep_q <= now_q;
            scan_idx_q   <= '0;
            rd_pend_q    <= 1'b0;
            free_q       <= 1'b0;
            forced_q     <= 1'b1;
            match_en_q   <= 1'b0;
            sweep_en_q   <= 1'b1;
          end
        end
        pctbl_pkg::ST_INSERT: begin
          count_q <= count_q + pctbl_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      v6_q     <= v6_in;
      key_hi_q <= key_hi_in;
      key_lo_q <= key_lo_in;
      now_q    <= req_i.now_ms;
      draw_q   <= req_i.random_draw;
      res_q    <= pctbl_pkg::VERDICT_ANSWER;
    end
    if (state_q == pctbl_pkg::ST_START) begin
      full_q  <= full_c;
      limit_q <= (full_c > pctbl_pkg::SWEEP_MS) ? full_c : pctbl_pkg::SWEEP_MS;
    end
    if ((state_q == pctbl_pkg::ST_DECIDE) && (state_d == pctbl_pkg::ST_SCAN)) begin
      limit_q <= full_q;
    end
    if (state_q == pctbl_pkg::ST_SCAN) begin
      if (match) begin
        hit_addr_q <= rd_addr_q;
        hit_ent_q  <= rd_ent;
      end
      if (slot_free && !free_q) begin
        free_addr_q <= rd_addr_q;
      end
      if (issue) begin
        rd_addr_q <= scan_idx_q[pctbl_pkg::IDX_W-1:0];
      end
    end
    if (div_start) begin
      el_q <= el_c;
    end
    if (state_q == pctbl_pkg::ST_REFILL) begin
      if (el_q >= full_q) begin
        refill_q <= cap;
      end else begin
        refill_q <= (sum > {1'b0, cap}) ? cap : sum[KW-1:0];
      end
    end
    if (state_q == pctbl_pkg::ST_APPLY) begin
      res_q <= apply_verdict;
    end
    if ((state_q == pctbl_pkg::ST_RESP) && (!rsp_valid_q || rsp_o.ready)) begin
      rsp_verdict_q <= res_q;
      rsp_count_q   <= count_q;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.verdict       = rsp_verdict_q;
  assign rsp_o.tracked_count = rsp_count_q;

`ifndef SYNTHESIS
  // the bucket count never exceeds the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pctbl_pkg::CNT_W'(pctbl_pkg::TABLE_ENTRIES))
    else $error("bucket count beyond table size");

  // the table is only written while a request is in work or during clearing
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pctbl_pkg::ST_IDLE || state_q == pctbl_pkg::ST_RESP) |-> !ram_we)
    else $error("table write outside of a transaction");

  // an insert adds exactly one bucket
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pctbl_pkg::ST_INSERT |=>
      count_q == $past(count_q) + pctbl_pkg::CNT_W'(1))
    else $error("insert did not bump bucket count");

  // the divider only finishes while the refill waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == pctbl_pkg::ST_DIV)
    else $error("divider result without a waiting refill");

  // an insert always has a free slot
  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pctbl_pkg::ST_INSERT |-> free_q)
    else $error("insert without a free slot");
`endif

endmodule

`default_nettype wire
